// ----- rtl/core/swrf_pkg.sv -----
// ----------------------------------------------------------------------------
// swrf_pkg
// Shared types and constants for the sliding window rank filter.
// ----------------------------------------------------------------------------
package swrf_pkg;

    // window length (number of samples ranked)
    localparam int WINDOW = 3;

    localparam int SAMPLE_W = 16;
    localparam int PCT_W    = 7;
    localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // reset value of the percentile register
    localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(50);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [SLOT_W-1:0]          t_slot;
    typedef logic [PCT_W-1:0]           t_pct;

    // one rank list entry: sample value and the window slot holding it
    typedef struct packed {
        t_sample value;
        t_slot   slot;
    } t_entry;

    // flags handed between neighbouring cells
    typedef struct packed {
        logic removed;   // the overwritten slot sits at or left of this cell
        logic ahead;     // compacted list entry here orders before the new one
    } t_link;

endpackage

// ----- rtl/core/swrf_if.sv -----
// ----------------------------------------------------------------------------
// swrf_if
// Valid/ready channels for the sample input and the ranked result.
// ----------------------------------------------------------------------------
interface swrf_in_if;
    logic              valid;
    logic              ready;
    swrf_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swrf_out_if;
    logic              valid;
    logic              ready;
    swrf_pkg::t_sample ranked_value;

    modport source (output valid, output ranked_value, input ready);
    modport sink   (input valid, input ranked_value, output ready);
endinterface

// ----- rtl/core/swrf_cell.sv -----
// ----------------------------------------------------------------------------
// swrf_cell
// One position of the sorted rank list. Removes the overwritten slot and
// inserts the new sample by compare-and-shift with its neighbours.
// ----------------------------------------------------------------------------
module swrf_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,       // item accepted this cycle
    input  swrf_pkg::t_slot     i_reset_slot,  // slot held here after reset
    input  swrf_pkg::t_entry    i_new,         // incoming sample and its slot
    input  swrf_pkg::t_entry    i_left,        // left neighbour entry
    input  swrf_pkg::t_entry    i_right,       // right neighbour entry
    input  logic                i_right_cmp,   // right neighbour orders before new
    input  swrf_pkg::t_link     i_link,        // from left neighbour
    input  swrf_pkg::t_pct      i_pct,
    input  swrf_pkg::t_pct      i_thr_lo,      // lowest percentile mapping here
    input  swrf_pkg::t_pct      i_thr_hi,      // lowest percentile of next rank
    input  logic                i_has_hi,
    output swrf_pkg::t_entry    o_entry,
    output logic                o_cmp,
    output swrf_pkg::t_link     o_link,
    output swrf_pkg::t_sample   o_sel_value    // next value if rank selected, else 0
);

    swrf_pkg::t_entry r_entry;
    swrf_pkg::t_entry n_entry;
    logic             match;
    logic             sel;

    // (value, slot) order against the new entry
    always_comb begin
        o_cmp = (r_entry.value < i_new.value) ||
                ((r_entry.value == i_new.value) && (r_entry.slot < i_new.slot));
    end

    assign match          = (r_entry.slot == i_new.slot);
    assign o_link.removed = i_link.removed | match;
    assign o_link.ahead   = o_link.removed ? i_right_cmp : o_cmp;
    assign o_entry        = r_entry;

    // pick from compacted list: keep, take new, or take the left or right neighbour
    always_comb begin
        if (o_link.ahead) begin
            n_entry = o_link.removed ? i_right : r_entry;
        end else if (i_link.ahead) begin
            n_entry = i_new;
        end else begin
            n_entry = i_link.removed ? r_entry : i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.value <= '0;
            r_entry.slot  <= i_reset_slot;
        end else if (i_shift) begin
            r_entry <= n_entry;
        end
    end

    // rank select for the result
    assign sel         = (i_pct >= i_thr_lo) && !(i_has_hi && (i_pct >= i_thr_hi));
    assign o_sel_value = sel ? n_entry.value : '0;

endmodule

// ----- rtl/core/sliding_window_rank_filter.sv -----
// ----------------------------------------------------------------------------
// sliding_window_rank_filter
// Order statistic filter over the last WINDOW samples, rank set by percentile.
// ----------------------------------------------------------------------------
//  channel       dir  handshake     payload
//  i_sample_ch   in   valid/ready   sample        s16
//  o_result_ch   out  valid/ready   ranked_value  s16
//  i_cfg_*       in   write enable  percentile    u7
//
//  One item per clock: the cell row updates in the accept cycle and the
//  result lands in the output register at that edge. Synchronous active low
//  reset: window zero, rank list 0..WINDOW-1, percentile 50. Input is
//  stalled only while a result waits untaken.
// ----------------------------------------------------------------------------
module sliding_window_rank_filter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    swrf_in_if.sink              i_sample_ch,
    swrf_out_if.source           o_result_ch,
    input  logic                 i_cfg_we,
    input  logic [6:0]           i_cfg_wdata
);

    localparam int W     = swrf_pkg::WINDOW;
    localparam int DEN   = (W > 1) ? 2 * (W - 1) : 1;

    swrf_pkg::t_pct    r_pct;
    swrf_pkg::t_slot   r_wptr;
    logic              r_out_valid;
    swrf_pkg::t_sample r_out_value;
    logic              shift;
    swrf_pkg::t_entry  new_entry;
    swrf_pkg::t_sample n_out_value;

    swrf_pkg::t_entry  entry   [W];
    logic              cmp     [W];
    swrf_pkg::t_link   link    [W];
    swrf_pkg::t_sample sel_val [W];

    // handshake
    assign i_sample_ch.ready     = !r_out_valid || o_result_ch.ready;
    assign shift                 = i_sample_ch.valid && i_sample_ch.ready;
    assign new_entry.value       = i_sample_ch.sample;
    assign new_entry.slot        = r_wptr;
    assign o_result_ch.valid     = r_out_valid;
    assign o_result_ch.ranked_value = r_out_value;

    // cell row
    for (genvar i = 0; i < W; i++) begin : g_cell
        localparam int LO  = (i == 0) ? 0 : (200 * i - 100 + DEN - 1) / DEN;
        localparam int HI  = (i == W - 1) ? 0 : (200 * (i + 1) - 100 + DEN - 1) / DEN;

        swrf_pkg::t_entry left_e;
        swrf_pkg::t_entry right_e;
        logic             right_c;
        swrf_pkg::t_link  in_link;

        if (i == 0) begin : g_first
            assign left_e          = entry[i];
            assign in_link.removed = 1'b0;
            assign in_link.ahead   = 1'b1;
        end else begin : g_mid
            assign left_e  = entry[i-1];
            assign in_link = link[i-1];
        end

        if (i == W - 1) begin : g_last
            assign right_e = entry[i];
            assign right_c = 1'b0;
        end else begin : g_inner
            assign right_e = entry[i+1];
            assign right_c = cmp[i+1];
        end

        swrf_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift      (shift),
            .i_reset_slot (swrf_pkg::SLOT_W'(i)),
            .i_new        (new_entry),
            .i_left       (left_e),
            .i_right      (right_e),
            .i_right_cmp  (right_c),
            .i_link       (in_link),
            .i_pct        (r_pct),
            .i_thr_lo     (swrf_pkg::PCT_W'(LO)),
            .i_thr_hi     (swrf_pkg::PCT_W'(HI)),
            .i_has_hi     (i != W - 1),
            .o_entry      (entry[i]),
            .o_cmp        (cmp[i]),
            .o_link       (link[i]),
            .o_sel_value  (sel_val[i])
        );
    end

    // one cell selected: OR the gated values
    always_comb begin
        n_out_value = '0;
        for (int k = 0; k < W; k++) begin
            n_out_value = n_out_value | sel_val[k];
        end
    end

    // percentile register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct <= swrf_pkg::PCT_RESET;
        end else if (i_cfg_we) begin
            r_pct <= i_cfg_wdata;
        end
    end

    // write pointer, wraps at window end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
        end else if (shift) begin
            if (r_wptr == swrf_pkg::SLOT_W'(W - 1)) begin
                r_wptr <= '0;
            end else begin
                r_wptr <= r_wptr + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (shift) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_out_value <= n_out_value;
        end
    end

endmodule

// ----- sim/sliding_window_rank_filter_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_rank_filter_test
// Self-checking bench for the rank filter: a behavioural rank list predicts
// each output item, and results are compared in order. Covers directed edge
// cases, percentile sweeps, random streams under idling and a long output
// stall.
// ----------------------------------------------------------------------------
module sliding_window_rank_filter_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int PCT_MAX      = 100;
    localparam int WINDOW       = swrf_pkg::WINDOW;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we;
    logic [6:0] cfg_wdata;

    swrf_in_if  sample_ch ();
    swrf_out_if result_ch ();

    sliding_window_rank_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (sample_ch),
        .o_result_ch (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // shadow of the filter state
    swrf_pkg::t_sample win_val   [WINDOW];
    swrf_pkg::t_slot   rank_list [WINDOW];
    int                wr_slot;
    swrf_pkg::t_pct    pct_reg;

    swrf_pkg::t_sample ranked_expect_q [$];
    int      fail_count   = 0;
    int      cycle_count  = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;
    int      hold_seq      = 0;

    always #4 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sliding_window_rank_filter_test: errors");
            $finish;
        end
    end

    // update the shadow window with one item and return the ranked value
    function automatic swrf_pkg::t_sample rank_predict(input swrf_pkg::t_sample s);
        swrf_pkg::t_slot kept [WINDOW];
        swrf_pkg::t_slot slot;
        int    n;
        int    pos;
        int    p;
        int    r;
        slot = swrf_pkg::t_slot'(wr_slot);
        win_val[wr_slot] = s;
        // drop the overwritten slot, keep the rest in order
        n = 0;
        for (int i = 0; i < WINDOW; i++) begin
            if (rank_list[i] != slot) begin
                kept[n] = rank_list[i];
                n++;
            end
        end
        // ties go to the lower slot
        pos = 0;
        while (pos < n && (win_val[kept[pos]] < s ||
                           (win_val[kept[pos]] == s && kept[pos] < slot)))
            pos++;
        for (int i = 0; i < WINDOW; i++) begin
            if (i < pos)
                rank_list[i] = kept[i];
            else if (i == pos)
                rank_list[i] = slot;
            else
                rank_list[i] = kept[i-1];
        end
        p = (pct_reg > PCT_MAX) ? PCT_MAX : int'(pct_reg);
        r = (2 * p * (WINDOW - 1) + 100) / 200;
        if (r > WINDOW - 1)
            r = WINDOW - 1;
        wr_slot = (wr_slot + 1) % WINDOW;
        return win_val[rank_list[r]];
    endfunction

    // offer one item, with random gaps, and record its result once taken
    task automatic send_sample(input swrf_pkg::t_sample s);
        while ($urandom_range(99) < send_idle_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        do @(posedge i_clk); while (!sample_ch.ready);
        ranked_expect_q.push_back(rank_predict(s));
    endtask

    // called in the step after the last send of a burst
    task automatic sender_quiet();
        sample_ch.valid <= 1'b0;
    endtask

    task automatic wait_result_drain();
        while (ranked_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write, only once the pipe is empty
    task automatic write_percentile(input swrf_pkg::t_pct v);
        wait_result_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        pct_reg    = v;
    endtask

    function automatic swrf_pkg::t_sample pick_sample();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1, 2, 3: return swrf_pkg::t_sample'(int'($urandom_range(8)) - 4);
            default: return swrf_pkg::t_sample'($urandom);
        endcase
    endfunction

    // output side: random stalls, plus a long hold on request
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // result checker
    initial begin
        swrf_pkg::t_sample want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_ch.valid && result_ch.ready) begin
                if (ranked_expect_q.size() == 0) begin
                    $error("ranked_value: unexpected item, got %0d",
                           result_ch.ranked_value);
                    fail_count++;
                end else begin
                    want = ranked_expect_q.pop_front();
                    if (result_ch.ranked_value !== want) begin
                        $error("ranked_value: expected %0d, actual %0d",
                               want, result_ch.ranked_value);
                        fail_count++;
                    end
                end
            end
        end
    end

    // zero slots rank alongside the first samples
    task automatic test_unfilled_window();
        send_sample(16'sd7);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        sender_quiet();
    endtask

    // equal values order by slot
    task automatic test_equal_samples();
        send_sample(16'sd0);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(-16'sd1);
        sender_quiet();
    endtask

    // rank selection at the extremes, above range and on rounding edges
    task automatic test_percentile_edges();
        swrf_pkg::t_pct edge_pct [7] = '{7'd0, 7'd100, 7'd127, 7'd24, 7'd25,
                                         7'd74, 7'd75};
        for (int i = 0; i < 7; i++) begin
            write_percentile(edge_pct[i]);
            send_sample(i[0] ? 16'sh7fff : 16'sh8000);
            if (i < 3)
                send_sample(16'sd0);
            sender_quiet();
        end
    endtask

    // random stream, percentile changed every few dozen items
    task automatic test_random_stream(input int n_items, input int idle_pct,
                                      input int stall);
        swrf_pkg::t_pct pick;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        for (int i = 0; i < n_items; i++) begin
            send_sample(pick_sample());
            if (i % 45 == 44) begin
                sender_quiet();
                case ($urandom_range(5))
                    0:       pick = 7'd0;
                    1:       pick = 7'd100;
                    2:       pick = 7'd127;
                    default: pick = swrf_pkg::t_pct'($urandom_range(127));
                endcase
                write_percentile(pick);
            end
        end
        sender_quiet();
        wait_result_drain();
    endtask

    // output held off while input keeps offering items
    task automatic test_output_hold();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_seq     <= hold_seq + 1;
        for (int i = 0; i < 30; i++)
            send_sample(pick_sample());
        sender_quiet();
        wait_result_drain();
    endtask

    initial begin
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        for (int i = 0; i < WINDOW; i++) begin
            win_val[i]   = '0;
            rank_list[i] = swrf_pkg::t_slot'(i);
        end
        wr_slot = 0;
        pct_reg = swrf_pkg::PCT_RESET;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unfilled_window();
        test_equal_samples();
        test_percentile_edges();
        test_random_stream(280, 0, 0);
        test_random_stream(280, 72, 0);
        test_random_stream(280, 0, 72);
        test_random_stream(280, 11, 11);
        test_output_hold();

        wait_result_drain();
        if (fail_count == 0)
            $display("sliding_window_rank_filter_test: clean");
        else
            $display("sliding_window_rank_filter_test: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/swrf_pkg.sv
rtl/core/swrf_if.sv
rtl/core/swrf_cell.sv
rtl/core/sliding_window_rank_filter.sv
sim/sliding_window_rank_filter_test.sv
